FILE: design/ewmu_pkg.sv
// Shared types, codes and sizes of the edge weight matrix unpacker.
package ewmu_pkg;

    // Default matrix size limit
    localparam int MAX_NODES_DEFAULT = 1024;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Field widths
    localparam int REQ_W     = 2;
    localparam int WEIGHT_W  = 32;
    localparam int INDEX_W   = 10;
    localparam int LAYOUT_W  = 2;
    localparam int NODES_W   = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = NODES_W;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_WEIGHT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_END     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

    // Layout codes
    localparam logic [LAYOUT_W-1:0] LAYOUT_LOWER_DIAG_ROW = 2'd0;
    localparam logic [LAYOUT_W-1:0] LAYOUT_FULL_MATRIX    = 2'd1;
    localparam logic [LAYOUT_W-1:0] LAYOUT_UPPER_ROW      = 2'd2;
    localparam logic [LAYOUT_W-1:0] LAYOUT_UNKNOWN        = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd1;

    // Input word
    typedef struct packed {
        logic [REQ_W-1:0]           req_type;
        logic signed [WEIGHT_W-1:0] weight_value;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [INDEX_W-1:0]         row_index;
        logic [INDEX_W-1:0]         col_index;
        logic signed [WEIGHT_W-1:0] cell_weight;
        logic                       section_complete;
        logic                       last;
    } t_out_word;

    // Matrix element command, front to back
    typedef struct packed {
        logic [INDEX_W-1:0]         row;
        logic [INDEX_W-1:0]         col;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       done;
        logic                       mirror;
    } t_cmd;

endpackage

FILE: design/ewmu_front.sv
// Front end: configuration registers, matrix walk and element commands.
module ewmu_front #(
    parameter int MAX_NODES = ewmu_pkg::MAX_NODES_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ewmu_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ewmu_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    input  ewmu_pkg::t_in_word                  i_word,
    output logic                                o_cmd_valid,
    output ewmu_pkg::t_cmd                      o_cmd
);

    localparam int CNT_W = $clog2(MAX_NODES + 1);

    logic [ewmu_pkg::LAYOUT_W-1:0] r_layout;
    logic [ewmu_pkg::NODES_W-1:0]  r_node_count;
    logic [CNT_W-1:0]              r_row, n_row;
    logic [CNT_W-1:0]              r_col, n_col;
    logic                          r_fin, n_fin;

    logic [CNT_W-1:0] nodes;
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] col_pos;
    logic [CNT_W-1:0] col_inc;
    logic [CNT_W-1:0] row_inc;

    // Clamp the node count and size the current row
    always_comb begin
        if (32'(r_node_count) > 32'(MAX_NODES)) begin
            nodes = CNT_W'(MAX_NODES);
        end else begin
            nodes = CNT_W'(r_node_count);
        end
        if (r_layout == ewmu_pkg::LAYOUT_UPPER_ROW) begin
            rows = (nodes != '0) ? nodes - CNT_W'(1) : '0;
        end else begin
            rows = nodes;
        end
        unique case (r_layout)
            ewmu_pkg::LAYOUT_LOWER_DIAG_ROW: begin
                len = r_row + CNT_W'(1);
            end
            ewmu_pkg::LAYOUT_FULL_MATRIX: begin
                len = nodes;
            end
            default: begin
                len = nodes - CNT_W'(1) - r_row;
            end
        endcase
        row_inc = r_row + CNT_W'(1);
        col_inc = r_col + CNT_W'(1);
        col_pos = (r_layout == ewmu_pkg::LAYOUT_UPPER_ROW) ? row_inc + r_col : r_col;
    end

    // Request decode and counter advance
    always_comb begin
        n_row       = r_row;
        n_col       = r_col;
        n_fin       = r_fin;
        o_cmd_valid = 1'b0;
        o_cmd.row    = ewmu_pkg::INDEX_W'(r_row);
        o_cmd.col    = ewmu_pkg::INDEX_W'(col_pos);
        o_cmd.weight = i_word.weight_value;
        o_cmd.done   = 1'b0;
        o_cmd.mirror = (r_layout != ewmu_pkg::LAYOUT_FULL_MATRIX) && (col_pos != r_row);
        if (i_valid) begin
            unique case (i_word.req_type)
                ewmu_pkg::REQ_RESTART: begin
                    n_row = '0;
                    n_col = '0;
                    n_fin = 1'b0;
                end
                ewmu_pkg::REQ_END: begin
                    n_fin = 1'b1;
                end
                ewmu_pkg::REQ_WEIGHT: begin
                    if (!r_fin && r_layout != ewmu_pkg::LAYOUT_UNKNOWN) begin
                        if (r_row >= rows || r_col >= len) begin
                            // empty matrix or counters left outside it
                            n_fin = 1'b1;
                        end else begin
                            o_cmd_valid = 1'b1;
                            if (col_inc >= len) begin
                                n_col = '0;
                                n_row = row_inc;
                                if (row_inc >= rows) begin
                                    o_cmd.done = 1'b1;
                                    n_fin      = 1'b1;
                                end
                            end else begin
                                n_col = col_inc;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Configuration and walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout     <= ewmu_pkg::LAYOUT_LOWER_DIAG_ROW;
            r_node_count <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_fin        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ewmu_pkg::CFG_LAYOUT:     r_layout <= i_cfg_data[ewmu_pkg::LAYOUT_W-1:0];
                    ewmu_pkg::CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_row <= n_row;
            r_col <= n_col;
            r_fin <= n_fin;
        end
    end

endmodule

FILE: design/ewmu_queue.sv
// Short command queue between the front and back ends.
module ewmu_queue #(
    parameter int DEPTH = ewmu_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ewmu_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output ewmu_pkg::t_cmd o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ewmu_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

FILE: design/ewmu_back.sv
// Back end: expands element commands into one or two result words.
module ewmu_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  ewmu_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                o_empty,
    output ewmu_pkg::t_out_word o_word,
    input  logic                i_pop
);

    logic                r_out_valid;
    ewmu_pkg::t_out_word r_out;
    logic                r_phase;

    logic                load;
    ewmu_pkg::t_out_word next_word;

    assign o_empty = !r_out_valid;
    assign o_word  = r_out;
    assign load    = i_cmd_valid && (!r_out_valid || i_pop);
    // a plain element, or the second pass of a mirrored one, releases the command
    assign o_cmd_pop = load && (r_phase || !i_cmd.mirror);

    // Word for the current pass
    always_comb begin
        next_word.cell_weight      = i_cmd.weight;
        next_word.section_complete = i_cmd.done;
        if (r_phase) begin
            next_word.row_index = i_cmd.col;
            next_word.col_index = i_cmd.row;
            next_word.last      = 1'b1;
        end else begin
            next_word.row_index = i_cmd.row;
            next_word.col_index = i_cmd.col;
            next_word.last      = !i_cmd.mirror;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= next_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_phase     <= !r_phase && i_cmd.mirror;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: design/edge_weight_matrix_unpacker_unit.sv
// Top level of the edge weight matrix unpacker.
//
// Takes weight tokens and produces matrix write words (row, column, weight).
// The front end takes one input word per cycle while its four-entry command
// queue has room; the back end hands out one result word per cycle while the
// receiver pops. A weight in the full matrix layout gives one word, an
// off-diagonal weight in the lower diagonal row or upper row layouts gives
// two, so the sustained rate is one weight per cycle in the full layout and
// lower in the symmetric layouts, set by the single result port. A result
// word passes through the command queue and the output register before it
// reaches the ports. Write layout and node count only while no results are
// pending.
module edge_weight_matrix_unpacker_unit #(
    parameter int MAX_NODES = ewmu_pkg::MAX_NODES_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ewmu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ewmu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  ewmu_pkg::t_in_word              i_req,
    output logic                            empty,
    input  logic                            pop,
    output ewmu_pkg::t_out_word             o_result
);

    logic           accept;
    logic           cmd_valid;
    ewmu_pkg::t_cmd cmd;
    logic           head_valid;
    ewmu_pkg::t_cmd head;
    logic           head_pop;

    assign accept = push && !full;

    // Walk state and command generation
    ewmu_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (accept),
        .i_word      (i_req),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    // Decoupling queue
    ewmu_queue #(
        .DEPTH (ewmu_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_cmd   (cmd),
        .i_pop   (head_pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head)
    );

    // Result expansion
    ewmu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head),
        .o_cmd_pop   (head_pop),
        .o_empty     (empty),
        .o_word      (o_result),
        .i_pop       (pop)
    );

endmodule

FILE: design/ewmu_checker.sv
// Port-level checks of the edge weight matrix unpacker, bound to the top level.
module ewmu_port_props (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input ewmu_pkg::t_out_word o_result
);

    // Nothing pending straight after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queue not clear after reset");

    // A waiting word holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("result word changed while stalled");

    // First word of a mirrored pair is followed at once by its mirror
    a_mirror_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && !o_result.last |=>
            !empty && o_result.row_index == $past(o_result.col_index)
            && o_result.col_index == $past(o_result.row_index))
        else $error("mirrored word missing or misplaced");

    // Both words of a pair carry the same weight and section flag; the second closes the pair
    a_mirror_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && !o_result.last |=>
            o_result.last && o_result.cell_weight == $past(o_result.cell_weight)
            && o_result.section_complete == $past(o_result.section_complete))
        else $error("mirrored word differs from its pair");

endmodule

bind edge_weight_matrix_unpacker_unit ewmu_port_props u_ewmu_port_props (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

FILE: tb/ewmu_checker.sv
`timescale 1ns / 100ps
// Checker for the edge weight matrix unpacker: predicts matrix write words and compares them.
module ewmu_checker #(
    parameter int MAX_NODES = ewmu_pkg::MAX_NODES_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ewmu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ewmu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_push,
    input  logic                            i_full,
    input  ewmu_pkg::t_in_word              i_req,
    input  logic                            i_empty,
    input  logic                            i_pop,
    input  ewmu_pkg::t_out_word             i_result,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_words_in,
    output int                              o_words_out
);
    import ewmu_pkg::*;

    // Shadow copy of the registers and the walk position
    logic [LAYOUT_W-1:0] layout_reg;
    logic [NODES_W-1:0]  node_reg;
    int                  row_cnt;
    int                  col_cnt;
    logic                sect_closed;
    logic                word_bad;

    // Matrix writes still owed by the block, oldest first
    t_out_word           pending_writes[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_words_in   = 0;
        o_words_out  = 0;
    end

    // Walk the matrix for one accepted word and queue the writes it causes
    task automatic unpack_word(input t_in_word word);
        int        n;
        int        rows;
        int        len;
        int        col;
        int        r;
        logic      mirror;
        logic      done;
        t_out_word wr;
        case (word.req_type)
            REQ_RESTART: begin
                row_cnt     = 0;
                col_cnt     = 0;
                sect_closed = 1'b0;
            end
            REQ_END: sect_closed = 1'b1;
            REQ_WEIGHT: begin
                if (!sect_closed && layout_reg != LAYOUT_UNKNOWN) begin
                    // node counts past the limit are clamped
                    n = (int'(node_reg) > MAX_NODES) ? MAX_NODES : int'(node_reg);
                    if (layout_reg == LAYOUT_UPPER_ROW) begin
                        rows = (n > 0) ? n - 1 : 0;
                    end else begin
                        rows = n;
                    end
                    case (layout_reg)
                        LAYOUT_LOWER_DIAG_ROW: len = row_cnt + 1;
                        LAYOUT_FULL_MATRIX:    len = n;
                        default:               len = n - 1 - row_cnt;
                    endcase
                    // empty matrix or position left outside it: close, no write
                    if (row_cnt >= rows || col_cnt >= len) begin
                        sect_closed = 1'b1;
                    end else begin
                        r      = row_cnt;
                        col    = (layout_reg == LAYOUT_UPPER_ROW) ? row_cnt + 1 + col_cnt
                                                                  : col_cnt;
                        mirror = (layout_reg != LAYOUT_FULL_MATRIX) && (col != row_cnt);
                        done   = 1'b0;
                        col_cnt++;
                        if (col_cnt >= len) begin
                            col_cnt = 0;
                            row_cnt++;
                            if (row_cnt >= rows) begin
                                done        = 1'b1;
                                sect_closed = 1'b1;
                            end
                        end
                        wr.row_index        = r[INDEX_W-1:0];
                        wr.col_index        = col[INDEX_W-1:0];
                        wr.cell_weight      = word.weight_value;
                        wr.section_complete = done;
                        wr.last             = !mirror;
                        pending_writes.push_back(wr);
                        // symmetric layouts: mirrored cell off the diagonal
                        if (mirror) begin
                            wr.row_index = col[INDEX_W-1:0];
                            wr.col_index = r[INDEX_W-1:0];
                            wr.last      = 1'b1;
                            pending_writes.push_back(wr);
                        end
                    end
                end
            end
            default: ; // unused request code, ignored
        endcase
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            word_bad = 1'b1;
        end
    endtask

    // Watch both channels and the register port
    always @(posedge i_clk) begin : monitor
        t_out_word want;
        if (!i_rst_n) begin
            layout_reg  = LAYOUT_LOWER_DIAG_ROW;
            node_reg    = '0;
            row_cnt     = 0;
            col_cnt     = 0;
            sect_closed = 1'b0;
            pending_writes.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_LAYOUT) begin
                    layout_reg = i_cfg_data[LAYOUT_W-1:0];
                end else if (i_cfg_idx == CFG_NODE_COUNT) begin
                    node_reg = i_cfg_data[NODES_W-1:0];
                end
            end
            // results leave before this edge's input is taken
            if (i_pop && !i_empty) begin
                o_words_out++;
                if (pending_writes.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual row %0d col %0d w %0d",
                             $time, i_result.row_index, i_result.col_index,
                             i_result.cell_weight);
                    o_fail_count++;
                end else begin
                    want     = pending_writes.pop_front();
                    word_bad = 1'b0;
                    check_field("row_index", want.row_index, i_result.row_index);
                    check_field("col_index", want.col_index, i_result.col_index);
                    check_field("cell_weight", want.cell_weight, i_result.cell_weight);
                    check_field("section_complete", want.section_complete,
                                i_result.section_complete);
                    check_field("last", want.last, i_result.last);
                    if (word_bad) begin
                        o_fail_count++;
                    end
                end
            end
            if (i_push && !i_full) begin
                o_words_in++;
                unpack_word(i_req);
            end
        end
        o_pending = pending_writes.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, stimulus, receiver stalls and the verdict.
module tb_top;
    import ewmu_pkg::*;

    localparam int               MAX_NODES     = MAX_NODES_DEFAULT;
    localparam logic [REQ_W-1:0] REQ_UNUSED    = 2'd3;
    localparam int               SETTLE_CYCLES = 12;
    localparam int               HOLD_CYCLES   = 300;
    localparam int               STALL_LIMIT   = 5000;
    localparam int               WEIGHT_TARGET = 1500;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  push;
    logic                  full;
    t_in_word              i_req;
    logic                  empty;
    logic                  pop;
    t_out_word             o_result;

    int                    fail_count;
    int                    pending_count;
    int                    words_in;
    int                    words_out;

    int                    burst_left   = 0;
    int                    weights_sent = 0;
    int                    cfg_writes   = 0;
    int                    holds_asked  = 0;
    int                    holds_done   = 0;
    logic [LAYOUT_W-1:0]   cfg_layout   = LAYOUT_LOWER_DIAG_ROW;

    edge_weight_matrix_unpacker_unit #(
        .MAX_NODES (MAX_NODES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_req      (i_req),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result)
    );

    ewmu_checker #(
        .MAX_NODES (MAX_NODES)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .i_full       (full),
        .i_req        (i_req),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_words_in   (words_in),
        .o_words_out  (words_out)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Weight mix: full-scale extremes, zero, minus one and random bits
    function automatic logic signed [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Offer one word, in bursts with random gaps between them
    task automatic send_word(input logic [REQ_W-1:0] req,
                             input logic signed [WEIGHT_W-1:0] weight);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push               <= 1'b1;
        i_req.req_type     <= req;
        i_req.weight_value <= weight;
        do @(posedge i_clk); while (full);
        if (req == REQ_WEIGHT && cfg_layout != LAYOUT_UNKNOWN) begin
            weights_sent++;
        end
    endtask

    // Stop offering, let every owed write drain, then allow for words in flight
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers, block idle
    task automatic set_config(input logic [LAYOUT_W-1:0] layout,
                              input logic [NODES_W-1:0] nodes);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LAYOUT;
        i_cfg_data <= CFG_DATA_W'(layout);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_NODE_COUNT;
        i_cfg_data <= nodes;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_layout = layout;
        cfg_writes += 2;
    endtask

    // Receiver: stall pattern of its own, plus long hold-offs on request
    initial begin : result_drain
        int seg_len;
        int mode;
        pop <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (holds_done < holds_asked) begin
                holds_done++;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            seg_len = $urandom_range(4, 48);
            mode    = $urandom_range(0, 3);
            repeat (seg_len) begin
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= ($urandom_range(0, 1) == 1);
                    2:       pop <= ($urandom_range(0, 3) == 0);
                    default: pop <= ~pop;
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Watchdog on handshake activity
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles, %0d writes still owed",
                         $time, quiet, pending_count);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        logic [LAYOUT_W-1:0] layout;
        logic [NODES_W-1:0]  nodes;
        logic [REQ_W-1:0]    noise;
        int                  n;
        int                  cells;
        int                  sections;

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_LAYOUT;
        i_cfg_data <= '0;
        push       <= 1'b0;
        i_req      <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // straight after reset: lower diagonal row with no nodes, empty matrix
        send_word(REQ_WEIGHT, 32'sh0000_0100);

        // lower diagonal row, two nodes: diagonal, mirrored, filling cell, then ignored
        settle();
        set_config(LAYOUT_LOWER_DIAG_ROW, 11'd2);
        send_word(REQ_RESTART, '0);
        send_word(REQ_WEIGHT, 32'sh7FFF_FFFF);
        send_word(REQ_WEIGHT, 32'sh8000_0000);
        send_word(REQ_WEIGHT, '0);
        send_word(REQ_WEIGHT, 32'hFFFF_FFFF);

        // upper row with one node holds nothing
        settle();
        set_config(LAYOUT_UPPER_ROW, 11'd1);
        send_word(REQ_RESTART, '0);
        send_word(REQ_WEIGHT, 32'sh0000_0180);

        // upper row, three nodes: close early, weight after close, reopen and fill
        settle();
        set_config(LAYOUT_UPPER_ROW, 11'd3);
        send_word(REQ_RESTART, '0);
        send_word(REQ_WEIGHT, 32'sh0000_0001);
        send_word(REQ_END, '0);
        send_word(REQ_WEIGHT, 32'sh0000_0002);
        send_word(REQ_RESTART, 32'hFFFF_FFFF);
        send_word(REQ_WEIGHT, 32'sh8000_0000);
        send_word(REQ_WEIGHT, 32'sh7FFF_FFFF);
        send_word(REQ_WEIGHT, 32'shFFFF_FF00);
        send_word(REQ_UNUSED, 32'sh1234_5678);

        // full matrix, then shrink it under the counters: position out of range
        settle();
        set_config(LAYOUT_FULL_MATRIX, 11'd2);
        send_word(REQ_RESTART, '0);
        send_word(REQ_WEIGHT, 32'sh0000_0010);
        send_word(REQ_WEIGHT, 32'sh0000_0020);
        send_word(REQ_WEIGHT, 32'sh0000_0030);
        settle();
        set_config(LAYOUT_FULL_MATRIX, 11'd1);
        send_word(REQ_WEIGHT, 32'sh0000_0040);

        // unrecognised layout writes nothing
        settle();
        set_config(LAYOUT_UNKNOWN, 11'd4);
        send_word(REQ_RESTART, '0);
        send_word(REQ_WEIGHT, 32'sh0000_0050);

        // largest matrix, upper row: first row runs up to the top column index
        settle();
        set_config(LAYOUT_UPPER_ROW, 11'd1024);
        holds_asked++;
        send_word(REQ_RESTART, '0);
        repeat (1030) send_word(REQ_WEIGHT, rand_weight());

        // node count past the limit is clamped
        settle();
        set_config(LAYOUT_FULL_MATRIX, 11'd2047);
        send_word(REQ_RESTART, '0);
        repeat (40) send_word(REQ_WEIGHT, rand_weight());

        // random sections: mostly well-formed walks, some noise and carried-over state
        while (weights_sent < WEIGHT_TARGET) begin
            settle();
            case ($urandom_range(0, 9))
                0, 1, 2: layout = LAYOUT_LOWER_DIAG_ROW;
                3, 4, 5: layout = LAYOUT_FULL_MATRIX;
                6, 7, 8: layout = LAYOUT_UPPER_ROW;
                default: layout = LAYOUT_UNKNOWN;
            endcase
            nodes = ($urandom_range(0, 15) == 0) ? NODES_W'($urandom_range(0, 2047))
                                                 : NODES_W'($urandom_range(0, 10));
            set_config(layout, nodes);
            if ($urandom_range(0, 7) == 0) begin
                holds_asked++;
            end
            n = (int'(nodes) > MAX_NODES) ? MAX_NODES : int'(nodes);
            case (layout)
                LAYOUT_LOWER_DIAG_ROW: cells = n * (n + 1) / 2;
                LAYOUT_FULL_MATRIX:    cells = n * n;
                LAYOUT_UPPER_ROW:      cells = (n > 0) ? n * (n - 1) / 2 : 0;
                default:               cells = 4;
            endcase
            if (cells > 150) begin
                cells = 150;
            end
            sections = $urandom_range(1, 3);
            repeat (sections) begin
                // now and then keep the walk position from the previous setting
                if ($urandom_range(0, 7) != 0) begin
                    send_word(REQ_RESTART, rand_weight());
                end
                n = cells + $urandom_range(0, 2);
                if ($urandom_range(0, 4) == 0) begin
                    n = $urandom_range(0, cells);
                end
                repeat (n) begin
                    if ($urandom_range(0, 23) == 0) begin
                        case ($urandom_range(0, 2))
                            0:       noise = REQ_END;
                            1:       noise = REQ_RESTART;
                            default: noise = REQ_UNUSED;
                        endcase
                        send_word(noise, rand_weight());
                    end else begin
                        send_word(REQ_WEIGHT, rand_weight());
                    end
                end
            end
        end

        settle();
        $display("Run: %0d input words (%0d live weights), %0d matrix writes checked",
                 words_in, weights_sent, words_out);
        $display("All four layouts, node counts 0 to 2047, %0d register writes, %0d hold-offs",
                 cfg_writes, holds_done);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
